// ===== design/nfa_pkg.sv =====
// Shared types, constants and helpers for the NFA word acceptor.
// Used by nfa_ctrl and nfa_word_acceptor; depends on nothing else.
package nfa_pkg;

  // Automaton size and derived widths
  localparam int NUM_STATES = 16;
  localparam int STATE_W    = $clog2(NUM_STATES);
  localparam int SYM_W      = 8;
  localparam int SYM_COUNT  = 1 << SYM_W;
  localparam int ADDR_W     = STATE_W + SYM_W;
  localparam int MEM_DEPTH  = NUM_STATES * SYM_COUNT;
  localparam int SCAN_W     = $clog2(NUM_STATES + 1);

  // Field widths fixed by the item format
  localparam int FIELD_STATE_W = 4;
  localparam int SET_W         = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;

  // Symbol that always counts as part of the alphabet
  localparam logic [SYM_W-1:0] LAMBDA_SYM = 8'h24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_STATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_MASK  = 1'b1;

  typedef enum logic [1:0] {
    ACT_ADD_TRANS = 2'd0,
    ACT_ADD_SYM   = 2'd1,
    ACT_WORD_SYM  = 2'd2,
    ACT_EMPTY     = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT  = 2'd0,
    VERDICT_NOFINAL = 2'd1,
    VERDICT_FOREIGN = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SCAN,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]               action;
    logic [FIELD_STATE_W-1:0] source_state;
    logic [SYM_W-1:0]         symbol;
    logic [FIELD_STATE_W-1:0] target_state;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       verdict;
    logic [SET_W-1:0] end_states;
  } out_item_t;

  // Sequencer controls handed to the datapath
  typedef struct packed {
    state_t             state;
    logic               accept;
    logic [ADDR_W-1:0]  clr_addr;
    logic [STATE_W-1:0] rd_idx;
    logic               acc_en;
    logic [STATE_W-1:0] acc_idx;
    logic               emit;
    logic               last_q;
  } seq_t;

  // One-hot bit of a state index, empty when the index is out of range
  function automatic logic [NUM_STATES-1:0] state_bit(input logic [FIELD_STATE_W-1:0] idx);
    logic [NUM_STATES-1:0] res;
    res = '0;
    if (int'(idx) < NUM_STATES) begin
      res = NUM_STATES'(1) << idx;
    end
    return res;
  endfunction

endpackage

// ===== design/nfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module nfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/nfa_ctrl.sv =====
// Sequencer of the NFA word acceptor: table clearing sweep, transition
// read-modify-write and the per-state scan. Uses nfa_pkg.
module nfa_ctrl import nfa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic [1:0] action,
  input  logic       last,
  input  logic       out_busy,
  output logic       item_stall,
  output seq_t       seq
);

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [SCAN_W-1:0] scan_cnt;
  logic              last_q;
  logic              accept;

  assign accept = item_valid && (state == ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (act_t'(action))
            ACT_ADD_TRANS: state_next = ST_ADD_RD;
            ACT_ADD_SYM:   state_next = ST_IDLE;
            ACT_WORD_SYM:  state_next = ST_SCAN;
            ACT_EMPTY:     state_next = ST_EMIT;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD_RD: state_next = ST_ADD_WR;
      ST_ADD_WR: state_next = ST_IDLE;
      ST_SCAN: begin
        if (scan_cnt == SCAN_W'(NUM_STATES)) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: state_next = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (!out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    item_stall   = (state != ST_IDLE);
    seq.state    = state;
    seq.accept   = accept;
    seq.clr_addr = clr_addr;
    seq.rd_idx   = scan_cnt[STATE_W-1:0];
    seq.acc_en   = (state == ST_SCAN) && (scan_cnt != '0);
    seq.acc_idx  = STATE_W'(scan_cnt - 1'b1);
    seq.emit     = (state == ST_EMIT) && !out_busy;
    seq.last_q   = last_q;
  end

  // State, sweep address and scan counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      scan_cnt <= '0;
      last_q   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (accept) begin
        scan_cnt <= '0;
        last_q   <= last;
      end else if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
    end
  end

endmodule

// ===== design/nfa_word_acceptor.sv =====
// Top level of the NFA word acceptor: transition table, alphabet bitmap,
// active set datapath and output register. Uses nfa_pkg, nfa_ctrl, nfa_ram.
//
//   channel   | signals                          | carries
//   ----------+----------------------------------+------------------------------
//   item      | item, item_valid, item_stall     | load, word symbol, empty word
//   result    | result, result_valid, result_stall | verdict and end state set
//   config    | cfg_we, cfg_index, cfg_data      | start_state, final_mask
//
// After reset the transition table and the alphabet are swept to zero, one entry a cycle,
// with item_stall high for the MEM_DEPTH (4096) entries; config writes are taken meanwhile.
// Word symbol: one table read per state through the single RAM read port, then a
// commit step, plus an emit step for a last symbol's result.
// Add transition: read, then write back. Add symbol: taken in the idle state.
// Empty word: straight to emit. A pending result waits in the output register while
// result_stall is high; a new result stalls the item side until it is taken.
module nfa_word_acceptor import nfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  in_item_t              item,
  input  logic                  item_valid,
  output logic                  item_stall,
  output out_item_t             result,
  output logic                  result_valid,
  input  logic                  result_stall,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  seq_t                     seq;
  logic [FIELD_STATE_W-1:0] start_state;
  logic [SET_W-1:0]         final_mask;
  logic [NUM_STATES-1:0]    active_set;
  logic [NUM_STATES-1:0]    acc;
  logic                     in_word;
  logic                     foreign_seen;
  logic [FIELD_STATE_W-1:0] src_q;
  logic [FIELD_STATE_W-1:0] dst_q;
  logic [SYM_W-1:0]         sym_q;
  logic [1:0]               res_verdict;
  logic [SET_W-1:0]         res_states;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic [NUM_STATES-1:0]    mem_wdata;
  logic [ADDR_W-1:0]        mem_raddr;
  logic [NUM_STATES-1:0]    mem_rdata;
  logic                     alpha_we;
  logic [SYM_W-1:0]         alpha_waddr;
  logic                     alpha_wdata;
  logic                     alpha_rdata;
  logic                     out_busy;

  assign out_busy = result_valid && result_stall;

  nfa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .action     (item.action),
    .last       (item.last),
    .out_busy   (out_busy),
    .item_stall (item_stall),
    .seq        (seq)
  );

  // Table port selection: clear sweep, transition write-back, scan reads
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {src_q[STATE_W-1:0], sym_q};
    mem_wdata = mem_rdata | state_bit(dst_q);
    mem_raddr = {src_q[STATE_W-1:0], sym_q};
    case (seq.state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = seq.clr_addr;
        mem_wdata = '0;
      end
      ST_ADD_WR: begin
        mem_we = (int'(src_q) < NUM_STATES) && (int'(dst_q) < NUM_STATES);
      end
      ST_SCAN: begin
        mem_raddr = {seq.rd_idx, sym_q};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  nfa_ram #(
    .WIDTH (NUM_STATES),
    .DEPTH (MEM_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Alphabet port selection: clear sweep, or set a symbol on an add-symbol item
  always_comb begin
    alpha_we    = seq.accept && (act_t'(item.action) == ACT_ADD_SYM);
    alpha_waddr = item.symbol;
    alpha_wdata = 1'b1;
    if (seq.state == ST_CLEAR) begin
      alpha_we    = 1'b1;
      alpha_waddr = seq.clr_addr[SYM_W-1:0];
      alpha_wdata = 1'b0;
    end
  end

  nfa_ram #(
    .WIDTH (1),
    .DEPTH (SYM_COUNT)
  ) u_alphabet (
    .clk   (clk),
    .we    (alpha_we),
    .waddr (alpha_waddr),
    .wdata (alpha_wdata),
    .raddr (sym_q),
    .rdata (alpha_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_state <= '0;
      final_mask  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_STATE: start_state <= cfg_data[FIELD_STATE_W-1:0];
        REG_FINAL_MASK:  final_mask  <= cfg_data[SET_W-1:0];
        default:         final_mask  <= final_mask;
      endcase
    end
  end

  // Latch item payload on accept
  always_ff @(posedge clk) begin
    if (seq.accept) begin
      src_q <= item.source_state;
      dst_q <= item.target_state;
      sym_q <= item.symbol;
    end
  end

  // Accumulate the table masks of active states during the scan
  always_ff @(posedge clk) begin
    if (seq.accept) begin
      acc <= '0;
    end else if (seq.acc_en && active_set[seq.acc_idx]) begin
      acc <= acc | mem_rdata;
    end
  end

  // Word state: active set, sticky foreign flag, open-word flag
  always_ff @(posedge clk) begin
    if (rst) begin
      active_set   <= '0;
      in_word      <= 1'b0;
      foreign_seen <= 1'b0;
    end else begin
      if (seq.accept) begin
        case (act_t'(item.action))
          ACT_WORD_SYM: begin
            in_word <= 1'b1;
            if (!in_word) begin
              active_set   <= state_bit(start_state);
              foreign_seen <= 1'b0;
            end
          end
          ACT_EMPTY: begin
            in_word      <= 1'b0;
            foreign_seen <= 1'b0;
            active_set   <= state_bit(start_state);
          end
          default: begin
            in_word <= in_word;
          end
        endcase
      end
      // Alphabet bit of the symbol arrives on the first scan step
      if (seq.acc_en && (seq.acc_idx == '0) && !alpha_rdata && (sym_q != LAMBDA_SYM)) begin
        foreign_seen <= 1'b1;
      end
      if (seq.state == ST_COMMIT) begin
        active_set <= acc;
        if (seq.last_q) begin
          in_word <= 1'b0;
        end
      end
    end
  end

  // Result held until the output register is free
  always_ff @(posedge clk) begin
    if (seq.accept && (act_t'(item.action) == ACT_EMPTY)) begin
      res_verdict <= VERDICT_ACCEPT;
      res_states  <= SET_W'(state_bit(start_state));
    end else if (seq.state == ST_COMMIT) begin
      if (foreign_seen) begin
        res_verdict <= VERDICT_FOREIGN;
      end else if ((SET_W'(acc) & final_mask) != '0) begin
        res_verdict <= VERDICT_ACCEPT;
      end else begin
        res_verdict <= VERDICT_NOFINAL;
      end
      res_states <= SET_W'(acc);
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (seq.emit) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq.emit) begin
      result.verdict    <= res_verdict;
      result.end_states <= res_states;
    end
  end

endmodule

// ===== tb/tb_nfa_word_acceptor.sv =====
// Testbench for nfa_word_acceptor: drives load, word and empty-word items,
// predicts verdict and end state set per word, and checks each result.
// Depends on nfa_pkg and the nfa_word_acceptor RTL only.
`timescale 1ns / 1ps

module tb_nfa_word_acceptor;
  import nfa_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int SETTLE_TICKS = 40;     // margin for a word symbol's scan, plus result
  localparam int HOLD_TICKS   = 300;    // long receiver hold-off for back-pressure
  localparam int STALL_LIMIT  = 20000;  // must exceed the reset clearing pass
  localparam int RAND_PHASES  = 4;
  localparam int PHASE_ITEMS  = 330;
  localparam int IN_ITEM_W    = $bits(in_item_t);

  logic                  clk;
  logic                  rst;
  in_item_t              item;
  logic                  item_valid;
  logic                  item_stall;
  out_item_t             result;
  logic                  result_valid;
  logic                  result_stall;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow automaton
  bit [SET_W-1:0] trans_mask [0:4095];
  bit             sym_known  [0:255];
  bit [SET_W-1:0] cur_set;
  bit             word_open;
  bit             saw_foreign;
  bit [3:0]       start_idx;
  bit [SET_W-1:0] accept_mask;

  out_item_t pending_verdicts[$];
  int        mismatch_count;
  int        stall_ticks;
  bit        no_gaps;
  bit        hold_off_req;
  logic [7:0] sym_pool [0:7];

  nfa_word_acceptor DUT (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic bit [SET_W-1:0] one_hot_state(input logic [3:0] idx);
    bit [SET_W-1:0] res;
    res = '0;
    if (int'(idx) < NUM_STATES) begin
      res[idx] = 1'b1;
    end
    return res;
  endfunction

  function automatic in_item_t make_item(input act_t act, input logic [3:0] src,
                                         input logic [7:0] sym, input logic [3:0] tgt,
                                         input logic lst);
    in_item_t it;
    it.action       = act;
    it.source_state = src;
    it.symbol       = sym;
    it.target_state = tgt;
    it.last         = lst;
    return it;
  endfunction

  // Advance the shadow automaton by one item and queue any verdict it causes
  task automatic track_item(input in_item_t it);
    out_item_t      want;
    bit [SET_W-1:0] nxt;
    case (act_t'(it.action))
      ACT_ADD_TRANS: begin
        if (int'(it.source_state) < NUM_STATES && int'(it.target_state) < NUM_STATES) begin
          trans_mask[{it.source_state, it.symbol}] |= one_hot_state(it.target_state);
        end
      end
      ACT_ADD_SYM: begin
        sym_known[it.symbol] = 1'b1;
      end
      ACT_WORD_SYM: begin
        if (!word_open) begin
          cur_set     = one_hot_state(start_idx);
          saw_foreign = 1'b0;
          word_open   = 1'b1;
        end
        if (!sym_known[it.symbol] && it.symbol != LAMBDA_SYM) begin
          saw_foreign = 1'b1;
        end
        nxt = '0;
        for (int s = 0; s < 16; s++) begin
          if (cur_set[s]) begin
            nxt |= trans_mask[{4'(s), it.symbol}];
          end
        end
        cur_set = nxt;
        if (it.last) begin
          word_open = 1'b0;
          if (saw_foreign) begin
            want.verdict = VERDICT_FOREIGN;
          end else if ((cur_set & accept_mask) != '0) begin
            want.verdict = VERDICT_ACCEPT;
          end else begin
            want.verdict = VERDICT_NOFINAL;
          end
          want.end_states = cur_set;
          pending_verdicts = {pending_verdicts, want};
        end
      end
      default: begin
        word_open       = 1'b0;
        saw_foreign     = 1'b0;
        cur_set         = one_hot_state(start_idx);
        want.verdict    = VERDICT_ACCEPT;
        want.end_states = cur_set;
        pending_verdicts = {pending_verdicts, want};
      end
    endcase
  endtask

  // Offer one item after a random gap; hold it until the block takes it
  task automatic send_item(input in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       = it;
    item_valid = 1'b1;
    do @(posedge clk); while (item_stall);
    track_item(it);
    @(negedge clk);
  endtask

  task automatic send_word_sym(input logic [7:0] sym, input logic lst);
    send_item(make_item(ACT_WORD_SYM, 4'($urandom), sym, 4'($urandom), lst));
  endtask

  task automatic send_trans(input logic [3:0] src, input logic [7:0] sym,
                            input logic [3:0] tgt);
    send_item(make_item(ACT_ADD_TRANS, src, sym, tgt, 1'($urandom)));
  endtask

  // Drop valid, wait for every verdict, then let in-flight loads finish
  task automatic wait_idle();
    item_valid = 1'b0;
    while (pending_verdicts.size() > 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_START_STATE) begin
      start_idx = data[3:0];
    end else begin
      accept_mask = data;
    end
  endtask

  // Pick a word symbol: mostly from the small pool, sometimes any byte
  function automatic logic [7:0] pick_sym();
    if ($urandom_range(0, 9) != 0) begin
      return sym_pool[$urandom_range(0, 7)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Words against the cleared table and empty alphabet at reset settings
  task automatic test_reset_defaults();
    send_item(make_item(ACT_EMPTY, 4'hF, 8'hFF, 4'hF, 1'b1));
    send_word_sym(8'h61, 1'b1);        // foreign symbol
    send_word_sym(LAMBDA_SYM, 1'b1);   // '$' is never foreign
  endtask

  // Build a small automaton and run words through it
  task automatic test_loads_and_words();
    send_item(make_item(ACT_ADD_SYM, 4'h0, 8'h61, 4'h0, 1'b0));
    send_item(make_item(ACT_ADD_SYM, 4'hF, 8'h00, 4'hF, 1'b1));
    send_item(make_item(ACT_ADD_SYM, 4'h3, 8'hFF, 4'h9, 1'b0));
    send_trans(4'd0, 8'h61, 4'd1);
    send_trans(4'd0, 8'h61, 4'd2);
    send_trans(4'd0, 8'h61, 4'd1);     // duplicate load
    send_trans(4'd1, LAMBDA_SYM, 4'd15);
    send_trans(4'd2, 8'h00, 4'd15);
    send_trans(4'd15, 8'hFF, 4'd0);
    send_trans(4'd15, 8'h00, 4'd15);
    // accepted word
    send_word_sym(8'h61, 1'b0);
    send_word_sym(LAMBDA_SYM, 1'b1);
    // non-final end set
    send_word_sym(8'h61, 1'b1);
    // foreign symbol in the middle
    send_word_sym(8'h61, 1'b0);
    send_word_sym(8'h62, 1'b0);
    send_word_sym(LAMBDA_SYM, 1'b1);
    // load lands while a word is open
    send_word_sym(8'h61, 1'b0);
    send_trans(4'd1, 8'hFF, 4'd3);
    send_word_sym(8'hFF, 1'b1);
    // empty word abandons an open word
    send_word_sym(8'h61, 1'b0);
    send_item(make_item(ACT_EMPTY, 4'h0, 8'h00, 4'h0, 1'b0));
  endtask

  // Extreme start states and final masks
  task automatic test_config_extremes();
    wait_idle();
    write_reg(REG_START_STATE, 16'hFFF5);  // upper bits dropped
    write_reg(REG_FINAL_MASK, 16'hFFFF);
    send_item(make_item(ACT_EMPTY, 4'h0, 8'h00, 4'h0, 1'b1));
    wait_idle();
    write_reg(REG_START_STATE, 16'h000F);
    send_word_sym(8'hFF, 1'b1);
    send_word_sym(8'h00, 1'b0);
    send_word_sym(8'h00, 1'b1);
  endtask

  // Random loads and well-formed words, with some noise items
  task automatic test_random_words();
    int sent;
    int roll;
    int len;
    for (int i = 0; i < 7; i++) begin
      sym_pool[i] = 8'($urandom_range(0, 255));
    end
    sym_pool[7] = LAMBDA_SYM;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(REG_START_STATE, 16'($urandom));
          write_reg(REG_FINAL_MASK, 16'($urandom));
        end
        1: begin
          write_reg(REG_START_STATE, 16'h000F);
          write_reg(REG_FINAL_MASK, 16'hFFFF);
        end
        2: begin
          write_reg(REG_START_STATE, 16'h0000);
          write_reg(REG_FINAL_MASK, 16'h0000);
        end
        default: begin
          write_reg(REG_START_STATE, 16'($urandom_range(0, 15)));
          write_reg(REG_FINAL_MASK, 16'(1) << $urandom_range(0, 15));
        end
      endcase
      no_gaps = (ph == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 14) begin
          send_trans(4'($urandom), pick_sym(), 4'($urandom));
          sent++;
        end else if (roll < 20) begin
          send_item(make_item(ACT_ADD_SYM, 4'($urandom),
                              ($urandom_range(0, 4) != 0) ? sym_pool[$urandom_range(0, 5)]
                                                          : 8'($urandom),
                              4'($urandom), 1'($urandom)));
          sent++;
        end else if (roll < 24) begin
          send_item(make_item(ACT_EMPTY, 4'($urandom), 8'($urandom), 4'($urandom),
                              1'($urandom)));
          sent++;
        end else if (roll < 28) begin
          send_item(in_item_t'(IN_ITEM_W'($urandom)));
          sent++;
        end else begin
          len = $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            send_word_sym(pick_sym(), k == len - 1);
          end
          sent += len;
        end
      end
      no_gaps = 1'b0;
    end
  endtask

  // Hold the result side off while short words keep coming
  task automatic test_backpressure();
    wait_idle();
    hold_off_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_word_sym(pick_sym(), 1'b1);
    end
  endtask

  // Receiver: random hold-off per item, or one long hold when asked
  initial begin
    int hold;
    result_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_stall = 1'b1;
        repeat (HOLD_TICKS) @(negedge clk);
      end else begin
        hold = no_gaps ? 0 : $urandom_range(0, 3);
        if (hold > 0) begin
          result_stall = 1'b1;
          repeat (hold) @(negedge clk);
        end
      end
      result_stall = 1'b0;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  // Compare each taken result with the oldest queued verdict
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual verdict %0d states %h",
                 $time, result.verdict, result.end_states);
      end else begin
        want = pending_verdicts.pop_front();
        if (result.verdict !== want.verdict) begin
          mismatch_count++;
          $display("%0t: verdict mismatch, expected %0d, actual %0d",
                   $time, want.verdict, result.verdict);
        end
        if (result.end_states !== want.end_states) begin
          mismatch_count++;
          $display("%0t: end_states mismatch, expected %h, actual %h",
                   $time, want.end_states, result.end_states);
        end
      end
    end
  end

  // Watchdog: count cycles with no item taken on either side
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      stall_ticks <= 0;
    end else begin
      stall_ticks <= stall_ticks + 1;
      if (stall_ticks >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    item           = '0;
    item_valid     = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    cur_set        = '0;
    word_open      = 1'b0;
    saw_foreign    = 1'b0;
    start_idx      = '0;
    accept_mask    = '0;
    mismatch_count = 0;
    no_gaps        = 1'b0;
    hold_off_req   = 1'b0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    wait_idle();
    write_reg(REG_START_STATE, 16'h0000);
    write_reg(REG_FINAL_MASK, 16'h8000);
    test_loads_and_words();
    test_config_extremes();
    test_random_words();
    test_backpressure();
    wait_idle();

    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
